// ----- src/sds_pkg.sv -----
// snare voice package: q24 constants, config register codes and reset values,
// datapath operand and op codes, control word layout and the microcode rom
// no dependencies
package sds_pkg;

  localparam int unsigned CfgW = 25;
  localparam int unsigned DataW = 32;
  localparam int unsigned StepW = 5;
  localparam logic [CfgW-1:0] ONE_Q24 = 25'h100_0000;

  typedef enum logic [2:0] {
    CFG_BODY_FREQ_ONE = 3'd0,
    CFG_BODY_FREQ_TWO = 3'd1,
    CFG_SNAP_FREQ     = 3'd2,
    CFG_BODY_DAMPING  = 3'd3,
    CFG_SNAP_DAMPING  = 3'd4,
    CFG_BODY_DECAY    = 3'd5,
    CFG_SNAP_DECAY    = 3'd6,
    CFG_SNAPPY        = 3'd7
  } cfg_idx_e;

  localparam logic [CfgW-1:0] RST_BODY_FREQ_ONE = 25'd776750;
  localparam logic [CfgW-1:0] RST_BODY_FREQ_TWO = 25'd2485600;
  localparam logic [CfgW-1:0] RST_SNAP_FREQ     = 25'd7170000;
  localparam logic [CfgW-1:0] RST_BODY_DAMPING  = 25'd2097152;
  localparam logic [CfgW-1:0] RST_SNAP_DAMPING  = 25'd5592405;
  localparam logic [CfgW-1:0] RST_BODY_DECAY    = 25'd16775525;
  localparam logic [CfgW-1:0] RST_SNAP_DECAY    = 25'd16772385;
  localparam logic [CfgW-1:0] RST_SNAPPY        = 25'd8388608;

  typedef struct packed {
    logic [CfgW-1:0] body_freq_one;
    logic [CfgW-1:0] body_freq_two;
    logic [CfgW-1:0] snap_freq;
    logic [CfgW-1:0] body_damping;
    logic [CfgW-1:0] snap_damping;
    logic [CfgW-1:0] body_decay;
    logic [CfgW-1:0] snap_decay;
    logic [CfgW-1:0] snappy;
  } cfg_t;

  // operand and destination codes of the datapath
  typedef enum logic [4:0] {
    SRC_ZERO,
    SRC_L1,
    SRC_B1,
    SRC_L2,
    SRC_B2,
    SRC_SL,
    SRC_SB,
    SRC_BE,
    SRC_SE,
    SRC_H,
    SRC_BODY,
    SRC_SNAP,
    SRC_MIX,
    SRC_X,
    SRC_N,
    SRC_F1,
    SRC_F2,
    SRC_SF,
    SRC_BQ,
    SRC_SQ,
    SRC_BD,
    SRC_SD,
    SRC_BG,
    SRC_SG
  } src_e;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_ACC,
    ALU_HIGH,
    ALU_HALF,
    ALU_MOV,
    ALU_MIX
  } alu_e;

  typedef enum logic {
    SQ_NEXT,
    SQ_END
  } seq_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  typedef struct packed {
    logic    mul_en;
    src_e    mul_a;
    src_e    mul_b;
    alu_e    alu;
    src_e    ra;
    src_e    rb;
    src_e    dst;
    seq_op_e seq;
  } ucode_t;

  typedef struct packed {
    logic   busy;
    logic   fire;
    ucode_t uc;
  } dp_ctrl_t;

  function automatic ucode_t uw(logic m, src_e a, src_e b, alu_e op, src_e ra,
                                src_e rb, src_e dst, seq_op_e sq);
    ucode_t w;
    w.mul_en = m;
    w.mul_a  = a;
    w.mul_b  = b;
    w.alu    = op;
    w.ra     = ra;
    w.rb     = rb;
    w.dst    = dst;
    w.seq    = sq;
    return w;
  endfunction

  // one sample: three filter steps, two envelope products, two decays, mix
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    case (step)
      5'd0:  w = uw(1'b1, SRC_F1, SRC_B1, ALU_NOP, SRC_ZERO, SRC_ZERO, SRC_ZERO, SQ_NEXT);
      5'd1:  w = uw(1'b1, SRC_BQ, SRC_B1, ALU_ACC, SRC_L1, SRC_ZERO, SRC_L1, SQ_NEXT);
      5'd2:  w = uw(1'b1, SRC_F2, SRC_B2, ALU_HIGH, SRC_X, SRC_L1, SRC_H, SQ_NEXT);
      5'd3:  w = uw(1'b1, SRC_F1, SRC_H, ALU_ACC, SRC_L2, SRC_ZERO, SRC_L2, SQ_NEXT);
      5'd4:  w = uw(1'b1, SRC_BQ, SRC_B2, ALU_ACC, SRC_B1, SRC_ZERO, SRC_B1, SQ_NEXT);
      5'd5:  w = uw(1'b1, SRC_SF, SRC_SB, ALU_HIGH, SRC_X, SRC_L2, SRC_H, SQ_NEXT);
      5'd6:  w = uw(1'b1, SRC_F2, SRC_H, ALU_ACC, SRC_SL, SRC_ZERO, SRC_SL, SQ_NEXT);
      5'd7:  w = uw(1'b1, SRC_SQ, SRC_SB, ALU_ACC, SRC_B2, SRC_ZERO, SRC_B2, SQ_NEXT);
      5'd8:  w = uw(1'b0, SRC_ZERO, SRC_ZERO, ALU_HIGH, SRC_N, SRC_SL, SRC_H, SQ_NEXT);
      5'd9:  w = uw(1'b1, SRC_SF, SRC_H, ALU_HALF, SRC_B1, SRC_B2, SRC_BODY, SQ_NEXT);
      5'd10: w = uw(1'b1, SRC_BODY, SRC_BE, ALU_ACC, SRC_SB, SRC_ZERO, SRC_SB, SQ_NEXT);
      5'd11: w = uw(1'b1, SRC_BE, SRC_BD, ALU_MOV, SRC_ZERO, SRC_ZERO, SRC_BODY, SQ_NEXT);
      5'd12: w = uw(1'b1, SRC_SB, SRC_SE, ALU_MOV, SRC_ZERO, SRC_ZERO, SRC_BE, SQ_NEXT);
      5'd13: w = uw(1'b1, SRC_SE, SRC_SD, ALU_MOV, SRC_ZERO, SRC_ZERO, SRC_SNAP, SQ_NEXT);
      5'd14: w = uw(1'b1, SRC_BODY, SRC_BG, ALU_MOV, SRC_ZERO, SRC_ZERO, SRC_SE, SQ_NEXT);
      5'd15: w = uw(1'b1, SRC_SNAP, SRC_SG, ALU_MOV, SRC_ZERO, SRC_ZERO, SRC_MIX, SQ_NEXT);
      5'd16: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ALU_MIX, SRC_MIX, SRC_ZERO, SRC_ZERO, SQ_END);
      default: w = uw(1'b0, SRC_ZERO, SRC_ZERO, ALU_NOP, SRC_ZERO, SRC_ZERO, SRC_ZERO,
                      SQ_END);
    endcase
    return w;
  endfunction

endpackage

// ----- src/sds_if.sv -----
// valid/ready channel interfaces of the snare voice: command word in, sample word out
// no dependencies
interface sds_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] velocity;
  logic signed [24:0] noise;

  modport source (output valid, output command, output velocity, output noise,
                  input ready);
  modport sink (input valid, input command, input velocity, input noise,
                output ready);
endinterface

interface sds_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ----- src/sds_sequencer.sv -----
// microcode sequencer: step counter, control rom lookup, end-of-program wait
// depends on sds_pkg
module sds_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  output sds_pkg::dp_ctrl_t ctrl_o
);

  sds_pkg::seq_state_e             state_q, state_d;
  logic [sds_pkg::StepW-1:0]       step_q, step_d;
  sds_pkg::ucode_t                 uc;

  assign uc = sds_pkg::ucode_rom(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sds_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ctrl_o.busy = 1'b0;
    ctrl_o.fire = 1'b0;
    ctrl_o.uc   = uc;
    case (state_q)
      sds_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = sds_pkg::ST_RUN;
          step_d  = '0;
        end
      end
      sds_pkg::ST_RUN: begin
        ctrl_o.busy = 1'b1;
        case (uc.seq)
          sds_pkg::SQ_END: begin
            // hold on the last step until the output register is free
            if (out_free_i) begin
              ctrl_o.fire = 1'b1;
              state_d     = sds_pkg::ST_IDLE;
              step_d      = '0;
            end
          end
          default: step_d = step_q + 1'b1;
        endcase
      end
      default: state_d = sds_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/sds_datapath.sv -----
// datapath: voice state, shared q24 multiplier with product register, alu,
// trigger load and saturated output word register
// depends on sds_pkg
module sds_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sds_pkg::cfg_t      cfg_i,
  input  sds_pkg::dp_ctrl_t  ctrl_i,
  input  logic               trig_i,
  input  logic               tick_i,
  input  logic signed [31:0] velocity_i,
  input  logic signed [24:0] noise_i,
  input  logic               out_ready_i,
  output logic               out_free_o,
  output logic               out_valid_o,
  output logic signed [15:0] out_sample_o
);

  localparam int unsigned W = sds_pkg::DataW;

  logic signed [W-1:0] imp_q, imp_d;
  logic signed [W-1:0] l1_q, b1_q, l2_q, b2_q, sl_q, sb_q, be_q, se_q;
  logic signed [W-1:0] h_q, body_q, snap_q, mix_q, x_q, n_q, p_q;
  logic                out_valid_q;
  logic signed [15:0]  sample_q;

  logic [sds_pkg::CfgW-1:0] vel_c, sn_c, bg_c;
  logic signed [W-1:0]      mul_a, mul_b, ra, rb, alu_y, mix_y;
  logic signed [2*W-1:0]    prod;
  logic signed [15:0]       sample_d;

  function automatic logic signed [W-1:0] ext(logic [sds_pkg::CfgW-1:0] v);
    return {{(W-sds_pkg::CfgW){1'b0}}, v};
  endfunction

  function automatic logic signed [W-1:0] rd(sds_pkg::src_e s);
    logic signed [W-1:0] v;
    case (s)
      sds_pkg::SRC_L1:   v = l1_q;
      sds_pkg::SRC_B1:   v = b1_q;
      sds_pkg::SRC_L2:   v = l2_q;
      sds_pkg::SRC_B2:   v = b2_q;
      sds_pkg::SRC_SL:   v = sl_q;
      sds_pkg::SRC_SB:   v = sb_q;
      sds_pkg::SRC_BE:   v = be_q;
      sds_pkg::SRC_SE:   v = se_q;
      sds_pkg::SRC_H:    v = h_q;
      sds_pkg::SRC_BODY: v = body_q;
      sds_pkg::SRC_SNAP: v = snap_q;
      sds_pkg::SRC_MIX:  v = mix_q;
      sds_pkg::SRC_X:    v = x_q;
      sds_pkg::SRC_N:    v = n_q;
      sds_pkg::SRC_F1:   v = ext(cfg_i.body_freq_one);
      sds_pkg::SRC_F2:   v = ext(cfg_i.body_freq_two);
      sds_pkg::SRC_SF:   v = ext(cfg_i.snap_freq);
      sds_pkg::SRC_BQ:   v = ext(cfg_i.body_damping);
      sds_pkg::SRC_SQ:   v = ext(cfg_i.snap_damping);
      sds_pkg::SRC_BD:   v = ext(cfg_i.body_decay);
      sds_pkg::SRC_SD:   v = ext(cfg_i.snap_decay);
      sds_pkg::SRC_BG:   v = ext(bg_c);
      sds_pkg::SRC_SG:   v = ext(sn_c);
      default:           v = '0;
    endcase
    return v;
  endfunction

  // velocity clamp and gains
  always_comb begin
    if (velocity_i[W-1]) begin
      vel_c = '0;
    end else if (velocity_i > ext(sds_pkg::ONE_Q24)) begin
      vel_c = sds_pkg::ONE_Q24;
    end else begin
      vel_c = velocity_i[sds_pkg::CfgW-1:0];
    end
    sn_c = (cfg_i.snappy > sds_pkg::ONE_Q24) ? sds_pkg::ONE_Q24 : cfg_i.snappy;
    bg_c = sds_pkg::ONE_Q24 - {1'b0, sn_c[sds_pkg::CfgW-1:1]};
  end

  assign imp_d = ext(vel_c) + (ext(vel_c) <<< 1);

  // operand selection
  always_comb begin
    mul_a = rd(ctrl_i.uc.mul_a);
    mul_b = rd(ctrl_i.uc.mul_b);
    ra    = rd(ctrl_i.uc.ra);
    rb    = rd(ctrl_i.uc.rb);
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    alu_y = '0;
    case (ctrl_i.uc.alu)
      sds_pkg::ALU_ACC:  alu_y = ra + p_q;
      sds_pkg::ALU_HIGH: alu_y = ra - rb - p_q;
      sds_pkg::ALU_HALF: alu_y = (ra + rb) >>> 1;
      sds_pkg::ALU_MOV:  alu_y = p_q;
      default:           alu_y = '0;
    endcase
  end

  // final sum, shift to q14 and saturate
  always_comb begin
    mix_y = ra + p_q;
    if (mix_y[W-1:25] != {(W-25){mix_y[W-1]}}) begin
      sample_d = mix_y[W-1] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sample_d = mix_y[25:10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.busy && ctrl_i.uc.mul_en) begin
      p_q <= prod[55:24];
    end
    if (tick_i) begin
      x_q <= imp_q;
      n_q <= {{(W-25){noise_i[24]}}, noise_i};
    end
    if (ctrl_i.fire) begin
      sample_q <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imp_q       <= '0;
      l1_q        <= '0;
      b1_q        <= '0;
      l2_q        <= '0;
      b2_q        <= '0;
      sl_q        <= '0;
      sb_q        <= '0;
      be_q        <= '0;
      se_q        <= '0;
      h_q         <= '0;
      body_q      <= '0;
      snap_q      <= '0;
      mix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (trig_i) begin
        imp_q <= imp_d;
        be_q  <= ext(sds_pkg::ONE_Q24);
        se_q  <= ext(vel_c);
      end else if (tick_i) begin
        imp_q <= '0;
      end
      if (ctrl_i.busy && ctrl_i.uc.alu != sds_pkg::ALU_NOP
          && ctrl_i.uc.alu != sds_pkg::ALU_MIX) begin
        case (ctrl_i.uc.dst)
          sds_pkg::SRC_L1:   l1_q   <= alu_y;
          sds_pkg::SRC_B1:   b1_q   <= alu_y;
          sds_pkg::SRC_L2:   l2_q   <= alu_y;
          sds_pkg::SRC_B2:   b2_q   <= alu_y;
          sds_pkg::SRC_SL:   sl_q   <= alu_y;
          sds_pkg::SRC_SB:   sb_q   <= alu_y;
          sds_pkg::SRC_BE:   be_q   <= alu_y;
          sds_pkg::SRC_SE:   se_q   <= alu_y;
          sds_pkg::SRC_H:    h_q    <= alu_y;
          sds_pkg::SRC_BODY: body_q <= alu_y;
          sds_pkg::SRC_SNAP: snap_q <= alu_y;
          sds_pkg::SRC_MIX:  mix_q  <= alu_y;
          default: ;
        endcase
      end
      if (ctrl_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o   = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = sample_q;

endmodule

// ----- src/snare_drum_voice_synth.sv -----
// snare drum voice, top level: config registers, input handshake,
// sequencer and datapath; depends on sds_pkg, sds_if, sds_sequencer, sds_datapath
//
// usage
//   in_i carries command words: command 1 is a trigger (velocity used), command 0
//   is a tick (noise used). a trigger makes no output word and does not start the program;
//   in_i stays ready after it. a tick makes exactly one sample word on out_o.
//   a tick runs a 17-step microprogram on one shared 32x32 multiplier, so
//   in_i drops ready once a tick is taken, and a new command word is taken
//   only after the program ends and writes its sample to the output register.
//   the program holds fifteen products and two steps that wait on a product.
//   out_o has a one-word output register: a new command word is taken while a
//   finished sample waits; if the receiver stalls, the next tick holds on its
//   last step until the output register frees, then in_i is ready again.
//   config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect the next cycle
//   and are meant for idle periods.
//   reset clears the voice state except the product, input and sample registers
//   and loads the default coefficients; the block is ready once reset is released.
module snare_drum_voice_synth (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sds_in_if.sink                   in_i,
  sds_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [sds_pkg::CfgW-1:0] cfg_wdata_i
);

  sds_pkg::cfg_t     cfg_q;
  sds_pkg::dp_ctrl_t ctrl;
  logic              in_fire, tick, trig, out_free;

  assign in_i.ready = !ctrl.busy;
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick       = in_fire && !in_i.command;
  assign trig       = in_fire && in_i.command;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.body_freq_one <= sds_pkg::RST_BODY_FREQ_ONE;
      cfg_q.body_freq_two <= sds_pkg::RST_BODY_FREQ_TWO;
      cfg_q.snap_freq     <= sds_pkg::RST_SNAP_FREQ;
      cfg_q.body_damping  <= sds_pkg::RST_BODY_DAMPING;
      cfg_q.snap_damping  <= sds_pkg::RST_SNAP_DAMPING;
      cfg_q.body_decay    <= sds_pkg::RST_BODY_DECAY;
      cfg_q.snap_decay    <= sds_pkg::RST_SNAP_DECAY;
      cfg_q.snappy        <= sds_pkg::RST_SNAPPY;
    end else if (cfg_we_i) begin
      case (sds_pkg::cfg_idx_e'(cfg_idx_i))
        sds_pkg::CFG_BODY_FREQ_ONE: cfg_q.body_freq_one <= cfg_wdata_i;
        sds_pkg::CFG_BODY_FREQ_TWO: cfg_q.body_freq_two <= cfg_wdata_i;
        sds_pkg::CFG_SNAP_FREQ:     cfg_q.snap_freq     <= cfg_wdata_i;
        sds_pkg::CFG_BODY_DAMPING:  cfg_q.body_damping  <= cfg_wdata_i;
        sds_pkg::CFG_SNAP_DAMPING:  cfg_q.snap_damping  <= cfg_wdata_i;
        sds_pkg::CFG_BODY_DECAY:    cfg_q.body_decay    <= cfg_wdata_i;
        sds_pkg::CFG_SNAP_DECAY:    cfg_q.snap_decay    <= cfg_wdata_i;
        sds_pkg::CFG_SNAPPY:        cfg_q.snappy        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sds_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tick),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  sds_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl),
    .trig_i       (trig),
    .tick_i       (tick),
    .velocity_i   (in_i.velocity),
    .noise_i      (in_i.noise),
    .out_ready_i  (out_o.ready),
    .out_free_o   (out_free),
    .out_valid_o  (out_o.valid),
    .out_sample_o (out_o.sample)
  );

endmodule

// ----- src/sds_checker.sv -----
// port-level checks of the snare voice and the bind that attaches them
// depends on snare_drum_voice_synth
module sds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_command_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_sample_i
);

  // a tick starts the program, so the input side closes
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_command_i) |=> !in_ready_i)
    else $error("input still ready after a tick word");

  // a trigger finishes at once
  a_trig_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_command_i) |=> in_ready_i)
    else $error("input not ready after a trigger word");

  // a new sample only ends a running program
  a_out_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("sample word appeared without a running program");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_sample_i)))
    else $error("stalled sample word changed");

endmodule

bind snare_drum_voice_synth sds_checker u_sds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample)
);
